// ----- hdl/wbc_pkg.sv -----
package wbc_pkg;

  localparam int unsigned WIN_W       = 4;
  localparam logic [WIN_W-1:0] WIN_RESET = 4'd5;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned BYTES_W     = 32;

  localparam logic REQ_PACKET = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic pkt;       // record the accepted packet
    logic q_load;    // start a window walk
    logic walk;      // advance the walk one bucket
    logic out_load;  // capture the result
  } ctrl_cmd_t;

  typedef struct packed {
    logic walk_done;
  } dpath_stat_t;

endpackage

// ----- hdl/wbc_req_if.sv -----
interface wbc_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic        outgoing;
  logic [31:0] time_sec;
  logic [15:0] packet_len;

  modport source (output valid, output req_type, output outgoing, output time_sec,
                  output packet_len, input ready);
  modport sink   (input valid, input req_type, input outgoing, input time_sec,
                  input packet_len, output ready);
endinterface

// ----- hdl/wbc_res_if.sv -----
interface wbc_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] sent_window_bytes;
  logic [31:0] recv_window_bytes;
  logic [31:0] sent_total_bytes;
  logic [31:0] recv_total_bytes;
  logic [31:0] last_seen_time;

  modport source (output valid, output sent_window_bytes, output recv_window_bytes,
                  output sent_total_bytes, output recv_total_bytes,
                  output last_seen_time, input ready);
  modport sink   (input valid, input sent_window_bytes, input recv_window_bytes,
                  input sent_total_bytes, input recv_total_bytes,
                  input last_seen_time, output ready);
endinterface

// ----- hdl/wbc_ctrl.sv -----
module wbc_ctrl
  import wbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_req_type,
  output logic        in_ready,
  input  logic        out_ready,
  output logic        out_valid,
  input  dpath_stat_t stat,
  output ctrl_cmd_t   cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_req_type == REQ_QUERY) begin
            cmd.q_load = 1'b1;
            state_nxt  = ST_WALK;
          end else begin
            cmd.pkt = 1'b1;
          end
        end
      end
      ST_WALK: begin
        if (stat.walk_done) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.walk = 1'b1;
        end
      end
      ST_FIN: begin
        // hold the sums until the output register frees up
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hdl/wbc_store.sv -----
module wbc_store
  import wbc_pkg::*;
#(
  parameter int unsigned BUCKETS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_cmd_t          cmd,
  input  logic               dir_hit,
  input  logic [TIME_W-1:0]  pkt_time,
  input  logic [LEN_W-1:0]   pkt_len,
  input  logic [TIME_W-1:0]  q_time,
  input  logic [WIN_W-1:0]   win,
  output logic [BYTES_W-1:0] sum,
  output logic               done
);

  localparam int unsigned IDXW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned CNTW = $clog2(BUCKETS + 1);
  localparam int unsigned KW   = $clog2(BUCKETS + 3);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(BUCKETS - 1);
  localparam logic [CNTW-1:0] FULL_CNT = CNTW'(BUCKETS);

  logic [TIME_W-1:0]  mem_time  [BUCKETS];
  logic [BYTES_W-1:0] mem_bytes [BUCKETS];

  logic [IDXW-1:0]    head_r, ptr_r;
  logic [CNTW-1:0]    count_r;
  logic [TIME_W-1:0]  head_time_r, rd_time_r;
  logic [BYTES_W-1:0] head_bytes_r, rd_bytes_r, sum_r;
  logic [KW-1:0]      k_r, eval_k_r;
  logic               eval_v_r, done_r;

  logic               same_sec, wr_en, expired;
  logic [IDXW-1:0]    head_inc, ptr_dec, wr_addr;
  logic [BYTES_W-1:0] wr_bytes;

  assign same_sec = (count_r != '0) && (head_time_r == pkt_time);
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign ptr_dec  = (ptr_r == '0) ? LAST_IDX : ptr_r - 1'b1;
  assign wr_addr  = same_sec ? head_r : head_inc;
  assign wr_bytes = same_sec ? head_bytes_r + BYTES_W'(pkt_len) : BYTES_W'(pkt_len);
  assign wr_en    = cmd.pkt && dir_hit;
  // 33-bit compare so that time plus window cannot wrap
  assign expired  = ({1'b0, rd_time_r} + (TIME_W + 1)'(win)) <= {1'b0, q_time};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_time[wr_addr]  <= pkt_time;
      mem_bytes[wr_addr] <= wr_bytes;
    end
    if (cmd.walk) begin
      rd_time_r  <= mem_time[ptr_r];
      rd_bytes_r <= mem_bytes[ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      count_r  <= '0;
      eval_v_r <= 1'b0;
      done_r   <= 1'b0;
      k_r      <= '0;
    end else if (wr_en) begin
      head_r <= wr_addr;
      if (!same_sec && count_r != FULL_CNT) count_r <= count_r + 1'b1;
    end else if (cmd.q_load) begin
      k_r      <= '0;
      eval_v_r <= 1'b0;
      done_r   <= 1'b0;
    end else if (cmd.walk) begin
      k_r      <= k_r + 1'b1;
      eval_v_r <= 1'b1;
      if (eval_v_r && !done_r) begin
        if (eval_k_r >= KW'(count_r)) begin
          done_r <= 1'b1;
        end else if (expired) begin
          // drop this bucket and everything older
          count_r <= eval_k_r[CNTW-1:0];
          done_r  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      head_time_r  <= pkt_time;
      head_bytes_r <= wr_bytes;
    end
    if (cmd.q_load) begin
      ptr_r <= head_r;
      sum_r <= '0;
    end else if (cmd.walk) begin
      ptr_r    <= ptr_dec;
      eval_k_r <= k_r;
      if (eval_v_r && !done_r && eval_k_r < KW'(count_r) && !expired) begin
        sum_r <= sum_r + rd_bytes_r;
      end
    end
  end

  assign sum  = sum_r;
  assign done = done_r;

endmodule

// ----- hdl/wbc_dpath.sv -----
module wbc_dpath
  import wbc_pkg::*;
#(
  parameter int unsigned BUCKETS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_cmd_t          cmd,
  output dpath_stat_t        stat,
  input  logic               cfg_we,
  input  logic [WIN_W-1:0]   cfg_wdata,
  input  logic               in_outgoing,
  input  logic [TIME_W-1:0]  in_time_sec,
  input  logic [LEN_W-1:0]   in_packet_len,
  output logic [BYTES_W-1:0] out_sent_window_bytes,
  output logic [BYTES_W-1:0] out_recv_window_bytes,
  output logic [BYTES_W-1:0] out_sent_total_bytes,
  output logic [BYTES_W-1:0] out_recv_total_bytes,
  output logic [TIME_W-1:0]  out_last_seen_time
);

  logic [WIN_W-1:0]   win_r;
  logic [TIME_W-1:0]  q_time_r, last_r;
  logic [BYTES_W-1:0] sent_cum_r, recv_cum_r;
  logic [BYTES_W-1:0] sent_sum, recv_sum;
  logic               sent_done, recv_done;

  logic [BYTES_W-1:0] o_sent_win_r, o_recv_win_r, o_sent_tot_r, o_recv_tot_r;
  logic [TIME_W-1:0]  o_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r      <= WIN_RESET;
      last_r     <= '0;
      sent_cum_r <= '0;
      recv_cum_r <= '0;
    end else begin
      if (cfg_we) win_r <= cfg_wdata;
      if (cmd.pkt) begin
        last_r <= in_time_sec;
        if (in_outgoing) sent_cum_r <= sent_cum_r + BYTES_W'(in_packet_len);
        else             recv_cum_r <= recv_cum_r + BYTES_W'(in_packet_len);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_load) q_time_r <= in_time_sec;
    if (cmd.out_load) begin
      o_sent_win_r <= sent_sum;
      o_recv_win_r <= recv_sum;
      o_sent_tot_r <= sent_cum_r;
      o_recv_tot_r <= recv_cum_r;
      o_last_r     <= last_r;
    end
  end

  wbc_store #(.BUCKETS(BUCKETS)) u_sent (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .dir_hit  (in_outgoing),
    .pkt_time (in_time_sec),
    .pkt_len  (in_packet_len),
    .q_time   (q_time_r),
    .win      (win_r),
    .sum      (sent_sum),
    .done     (sent_done)
  );

  wbc_store #(.BUCKETS(BUCKETS)) u_recv (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .dir_hit  (!in_outgoing),
    .pkt_time (in_time_sec),
    .pkt_len  (in_packet_len),
    .q_time   (q_time_r),
    .win      (win_r),
    .sum      (recv_sum),
    .done     (recv_done)
  );

  assign stat.walk_done = sent_done && recv_done;

  assign out_sent_window_bytes = o_sent_win_r;
  assign out_recv_window_bytes = o_recv_win_r;
  assign out_sent_total_bytes  = o_sent_tot_r;
  assign out_recv_total_bytes  = o_recv_tot_r;
  assign out_last_seen_time    = o_last_r;

endmodule

// ----- hdl/windowed_byte_counter_core.sv -----
// channel   dir  handshake       beat contents
// in_bus    in   valid/ready     req_type, outgoing, time_sec, packet_len
// out_bus   out  valid/ready     sent/recv window bytes, sent/recv totals, last time
// cfg       in   cfg_we          cfg_wdata = window_seconds
//
// Packet beats are taken whenever the controller is idle. A query walks both stores in
// parallel, one bucket per cycle, each store up to its first expired bucket or its stored
// count; the sums then wait in ST_FIN until the output register is free, and the next
// beat is taken once the controller is back in ST_IDLE.
// Reset (rst_n low, synchronous) empties both stores and clears totals; window is 5.
// A waiting result does not block packet beats; a second query walks, then holds its sums.
module windowed_byte_counter_core
  import wbc_pkg::*;
#(
  parameter int unsigned BUCKETS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [WIN_W-1:0] cfg_wdata,
  wbc_req_if.sink          in_bus,
  wbc_res_if.source        out_bus
);

  ctrl_cmd_t   cmd;
  dpath_stat_t stat;

  wbc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_bus.valid),
    .in_req_type (in_bus.req_type),
    .in_ready    (in_bus.ready),
    .out_ready   (out_bus.ready),
    .out_valid   (out_bus.valid),
    .stat        (stat),
    .cmd         (cmd)
  );

  wbc_dpath #(.BUCKETS(BUCKETS)) u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .in_outgoing           (in_bus.outgoing),
    .in_time_sec           (in_bus.time_sec),
    .in_packet_len         (in_bus.packet_len),
    .out_sent_window_bytes (out_bus.sent_window_bytes),
    .out_recv_window_bytes (out_bus.recv_window_bytes),
    .out_sent_total_bytes  (out_bus.sent_total_bytes),
    .out_recv_total_bytes  (out_bus.recv_total_bytes),
    .out_last_seen_time    (out_bus.last_seen_time)
  );

endmodule
